>>> rtl/ptteq_pkg.sv
package ptteq_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TICK   = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NULL_CB  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    localparam logic [0:0] REG_TICK_RATE    = 1'd0;
    localparam logic [0:0] REG_SLICE_LENGTH = 1'd1;

    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [9:0]  MS_PER_S   = 10'd1000;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] wait_ms;
        logic [15:0] callback_id;
        logic [31:0] event_data;
        logic [63:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] fired_callback;
        logic [31:0] fired_data;
        logic [8:0]  removed_count;
        logic [63:0] tick_count;
        logic [63:0] seconds;
        logic [9:0]  milliseconds;
        logic [63:0] next_deadline;
        logic [31:0] missed_count;
        logic        last;
    } out_item_t;

endpackage

>>> rtl/periodic_tick_timer_event_queue_top.sv
// Sequencing: start/stop/other answer directly from dispatch; remove and add sweep the N
//   queued entries; tick runs a 64-step restoring divide and a 30-step ms divide, then
//   reads the head and shifts the table for each fired event, waiting on any output stall.
// Throughput: one transaction at a time; the next is taken the cycle after the last
//   result leaves.
// The queue lives in one synchronous memory (registered read); edits are read-modify-write
//   sweeps through a sequencer. Reset (async, active low) clears counters, deadline,
//   running flag and entry count; memory contents are left undefined and never read stale.
module periodic_tick_timer_event_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ptteq_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ptteq_pkg::out_item_t          out_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ptteq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ptteq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [63:0] expiry;
        logic [15:0] owner;
        logic [31:0] payload;
    } entry_t;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DISPATCH= 14'b00000000000010,
        S_ASCAN   = 14'b00000000000100, // issue read of entry idx
        S_ACMP    = 14'b00000000001000, // compare read data
        S_ASHIFT  = 14'b00000000010000, // shift entries up from tail
        S_RSCAN   = 14'b00000000100000,
        S_RCMP    = 14'b00000001000000,
        S_DIV     = 14'b00000010000000, // tick_total / rate
        S_MSMUL   = 14'b00000100000000,
        S_MSDIV   = 14'b00001000000000,
        S_FREAD   = 14'b00010000000000, // read head
        S_FCHK    = 14'b00100000000000,
        S_FSHIFT  = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    // memory
    entry_t mem [QUEUE_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    state_t        state_reg, state_next;
    in_item_t      item_reg;
    out_item_t     out_reg;
    logic          out_valid_reg;
    logic [19:0]   tick_rate_reg;
    logic [31:0]   slice_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next, wr_reg, wr_next;
    logic [63:0]   ticks_reg, ticks_next, secs_reg, secs_next, dl_reg, dl_next;
    logic [9:0]    ms_reg, ms_next;
    logic [31:0]   missed_reg, missed_next;
    logic          run_reg, run_next;
    logic [63:0]   exp_reg, exp_next;
    // shared restoring divider
    logic [63:0]   quo_reg, quo_next;
    logic [19:0]   rem_reg, rem_next;
    logic [6:0]    step_reg, step_next;
    logic [29:0]   prod_reg, prod_next;
    logic [63:0]   cur_ms_reg, cur_ms_next;
    logic          do_out, out_last, out_fire;
    logic [1:0]    o_kind, o_status;
    logic [8:0]    o_removed;
    // remember what to do after a fired event leaves
    logic          resume_reg;

    logic [19:0] rate;
    logic [20:0] rem_shift;
    assign rate = (tick_rate_reg == '0) ? 20'd1 : tick_rate_reg;

    // seconds * 1000 as 1024 - 16 - 8
    logic [63:0] secs_x1000;
    assign secs_x1000 = (secs_reg << 10) - (secs_reg << 4) - (secs_reg << 3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= 20'd100;
            slice_reg     <= 32'd100000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TICK_RATE)
                tick_rate_reg <= cfg_wdata[19:0];
            else
                slice_reg <= cfg_wdata;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic [63:0] dl_adv;
    logic [64:0] ms_sum;
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        wr_next = wr_reg;
        ticks_next = ticks_reg;
        secs_next = secs_reg;
        ms_next = ms_reg;
        dl_next = dl_reg;
        missed_next = missed_reg;
        run_next = run_reg;
        exp_next = exp_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        cur_ms_next = cur_ms_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = mem_rdata_reg;
        mem_raddr = idx_reg[AW-1:0];
        do_out = 1'b0;
        out_last = 1'b1;
        out_fire = 1'b0;
        o_kind = KIND_ACK;
        o_status = ST_OK;
        o_removed = '0;
        rem_shift = '0;
        dl_adv = dl_reg + {32'd0, slice_reg};
        ms_sum = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (item_reg.operation)
                    OP_ADD:
                    begin
                        if (item_reg.callback_id == '0)
                        begin
                            o_status = ST_NULL_CB; do_out = 1'b1;
                        end
                        else if (count_reg >= CW'(QUEUE_DEPTH))
                        begin
                            o_status = ST_FULL; do_out = 1'b1;
                        end
                        else
                        begin
                            exp_next = cur_ms_reg + {32'd0, item_reg.wait_ms};
                            idx_next = '0;
                            state_next = S_ASCAN;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (item_reg.callback_id == '0)
                        begin
                            o_status = ST_NULL_CB; do_out = 1'b1;
                        end
                        else
                        begin
                            idx_next = '0; wr_next = '0;
                            state_next = S_RSCAN;
                        end
                    end
                    OP_TICK:
                    begin
                        if (!run_reg)
                        begin
                            o_kind = KIND_TICK; o_status = ST_DISABLED; do_out = 1'b1;
                        end
                        else
                        begin
                            ticks_next = ticks_reg + 64'd1;
                            quo_next = ticks_reg + 64'd1;
                            rem_next = '0;
                            step_next = '0;
                            state_next = S_DIV;
                        end
                    end
                    OP_START:
                    begin
                        if (!run_reg)
                        begin
                            dl_next = item_reg.now + {32'd0, slice_reg};
                            run_next = 1'b1;
                        end
                        do_out = 1'b1;
                    end
                    OP_STOP:
                    begin
                        run_next = 1'b0; do_out = 1'b1;
                    end
                    default: do_out = 1'b1;
                endcase
            end
            // insertion: find first entry with expiry > exp
            S_ASCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next = count_reg;
                    wr_next = idx_reg;
                    state_next = S_ASHIFT;
                end
                else
                    state_next = S_ACMP;
            end
            S_ACMP:
            begin
                if (mem_rdata_reg.expiry > exp_reg)
                begin
                    wr_next = idx_reg;
                    idx_next = count_reg;
                    state_next = S_ASHIFT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_ASCAN;
                end
            end
            // idx = slot being filled; read idx-1, wait, write
            S_ASHIFT:
            begin
                if (idx_reg == wr_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = wr_reg[AW-1:0];
                    mem_wdata = '{expiry: exp_reg, owner: item_reg.callback_id,
                                  payload: item_reg.event_data};
                    count_next = count_reg + 1'b1;
                    do_out = 1'b1;
                end
                else
                begin
                    mem_raddr = AW'(idx_reg - 1'b1);
                    if (step_reg[0])
                    begin
                        mem_we = 1'b1;
                        idx_next = idx_reg - 1'b1;
                    end
                    step_next = {6'd0, ~step_reg[0]};
                end
            end
            S_RSCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    o_removed = 9'(count_reg - wr_reg);
                    count_next = wr_reg;
                    do_out = 1'b1;
                end
                else
                    state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (mem_rdata_reg.owner != item_reg.callback_id)
                begin
                    mem_we = 1'b1;
                    mem_waddr = wr_reg[AW-1:0];
                    wr_next = wr_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = S_RSCAN;
            end
            // one quotient bit per cycle
            S_DIV:
            begin
                rem_shift = {rem_reg, quo_reg[63]};
                if (rem_shift >= {1'b0, rate})
                begin
                    rem_next = 20'(rem_shift - {1'b0, rate});
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[19:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 7'd63)
                    state_next = S_MSMUL;
            end
            S_MSMUL:
            begin
                secs_next = quo_reg;
                prod_next = 30'(rem_reg) * 30'(MS_PER_S);
                rem_next = '0;
                step_next = '0;
                state_next = S_MSDIV;
            end
            // 30-bit product over rate; result < 1000
            S_MSDIV:
            begin
                rem_shift = {rem_reg, prod_reg[29]};
                if (rem_shift >= {1'b0, rate})
                begin
                    rem_next = 20'(rem_shift - {1'b0, rate});
                    prod_next = {prod_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[19:0];
                    prod_next = {prod_reg[28:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 7'd29)
                begin
                    ms_next = prod_next[9:0];
                    state_next = S_FREAD;
                end
            end
            S_FREAD:
            begin
                ms_sum = {1'b0, secs_x1000} + {55'd0, ms_reg};
                cur_ms_next = ms_sum[63:0];
                mem_raddr = '0;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (count_reg != '0 && mem_rdata_reg.expiry <= cur_ms_reg)
                begin
                    o_kind = KIND_FIRE; out_last = 1'b0; out_fire = 1'b1;
                    do_out = 1'b1;
                    idx_next = '0;
                    step_next = '0;
                end
                else
                begin
                    if (item_reg.now > dl_adv)
                    begin
                        if (missed_reg != '1)
                            missed_next = missed_reg + 1'b1;
                        dl_next = item_reg.now + {32'd0, slice_reg};
                    end
                    else
                        dl_next = dl_adv;
                    o_kind = KIND_TICK; do_out = 1'b1;
                end
            end
            // move entry idx+1 to idx
            S_FSHIFT:
            begin
                mem_raddr = AW'(idx_reg + 1'b1);
                if (CW'(idx_reg + 1'b1) >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FREAD;
                end
                else if (step_reg[0])
                begin
                    mem_we = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    step_next = '0;
                end
                else
                    step_next = 7'd1;
            end
            // wait for the result to leave; after a fired event, close the gap in the table, else go idle
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = resume_reg ? S_FSHIFT : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (do_out)
            state_next = S_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg <= '0;
            ticks_reg <= '0;
            secs_reg <= '0;
            ms_reg <= '0;
            dl_reg <= '0;
            missed_reg <= '0;
            run_reg <= 1'b0;
            cur_ms_reg <= '0;
            resume_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ASHIFT && idx_reg == wr_reg)
                step_reg <= '0;
            else
                step_reg <= step_next;
            count_reg <= count_next;
            ticks_reg <= ticks_next;
            secs_reg <= secs_next;
            ms_reg <= ms_next;
            dl_reg <= dl_next;
            missed_reg <= missed_next;
            run_reg <= run_next;
            // cur_ms kept current for add; refreshed during each tick once the divides finish
            if (state_reg == S_FREAD)
                cur_ms_reg <= cur_ms_next;
            if (do_out)
            begin
                out_valid_reg <= 1'b1;
                resume_reg <= out_fire;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register loads only when free (S_OUT waits otherwise)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        idx_reg <= idx_next;
        wr_reg <= wr_next;
        exp_reg <= exp_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        prod_reg <= prod_next;
        if (do_out)
        begin
            out_reg.kind <= o_kind;
            out_reg.status <= o_status;
            out_reg.fired_callback <= out_fire ? mem_rdata_reg.owner : 16'd0;
            out_reg.fired_data <= out_fire ? mem_rdata_reg.payload : 32'd0;
            out_reg.removed_count <= o_removed;
            out_reg.tick_count <= ticks_next;
            out_reg.seconds <= secs_next;
            out_reg.milliseconds <= ms_next;
            out_reg.next_deadline <= dl_next;
            out_reg.missed_count <= missed_next;
            out_reg.last <= out_last;
        end
    end

    // a result is only produced while the output register is empty
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        do_out |-> !out_valid_reg)
        else $error("output overwritten");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count overflow");
    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg < MS_PER_S)
        else $error("ms out of range");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted while busy");
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ptteq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 20000;

    // Pending result store plus the checker: the timer predictor pushes the
    // expected results of each input transaction, the output side pops them.
    class timer_scoreboard;
        out_item_t pending[$];
        int errors;
        int checked;

        function void note_input(out_item_t produced[$]);
            foreach (produced[i])
                pending.push_back(produced[i]);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("tb: mismatch on %s: got %0h expected %0h (result %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result kind", got.kind, 0);
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.status != want.status) report("status", got.status, want.status);
            if (got.fired_callback != want.fired_callback)
                report("fired_callback", got.fired_callback, want.fired_callback);
            if (got.fired_data != want.fired_data)
                report("fired_data", got.fired_data, want.fired_data);
            if (got.removed_count != want.removed_count)
                report("removed_count", got.removed_count, want.removed_count);
            if (got.tick_count != want.tick_count)
                report("tick_count", got.tick_count, want.tick_count);
            if (got.seconds != want.seconds) report("seconds", got.seconds, want.seconds);
            if (got.milliseconds != want.milliseconds)
                report("milliseconds", got.milliseconds, want.milliseconds);
            if (got.next_deadline != want.next_deadline)
                report("next_deadline", got.next_deadline, want.next_deadline);
            if (got.missed_count != want.missed_count)
                report("missed_count", got.missed_count, want.missed_count);
            if (got.last != want.last) report("last", got.last, want.last);
            checked++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always #5 clk = ~clk;

    periodic_tick_timer_event_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    timer_scoreboard sb = new();

    // ---- timer predictor state ----
    logic [19:0] rate_reg;
    logic [31:0] slice_reg;
    logic [63:0] q_expiry[DEPTH];
    logic [15:0] q_owner[DEPTH];
    logic [31:0] q_payload[DEPTH];
    int          q_count;
    logic [63:0] ticks;
    logic [63:0] secs;
    logic [9:0]  msecs;
    logic [63:0] next_dl;
    logic [31:0] missed;
    logic        enabled;

    // idle percentages for the current phase
    int send_idle_pct;
    int recv_stall_pct;
    int fires_seen = 0;

    function automatic out_item_t make_result(logic [1:0] k, logic [1:0] st,
                                              logic [15:0] cb, logic [31:0] d,
                                              logic [8:0] rem, logic lst);
        out_item_t r;
        r.kind = k;
        r.status = st;
        r.fired_callback = cb;
        r.fired_data = d;
        r.removed_count = rem;
        r.tick_count = ticks;
        r.seconds = secs;
        r.milliseconds = msecs;
        r.next_deadline = next_dl;
        r.missed_count = missed;
        r.last = lst;
        return r;
    endfunction

    // Apply one input transaction to the predictor, return its results.
    function automatic void predict_timer(in_item_t it, ref out_item_t res[$]);
        logic [63:0] exp_ms;
        logic [63:0] rate;
        logic [63:0] now_ms;
        int pos;
        int wr;
        res = {};
        case (it.operation)
            OP_ADD:
            begin
                if (it.callback_id == 0)
                    res.push_back(make_result(KIND_ACK, ST_NULL_CB, 0, 0, 0, 1'b1));
                else if (q_count >= DEPTH)
                    res.push_back(make_result(KIND_ACK, ST_FULL, 0, 0, 0, 1'b1));
                else
                begin
                    exp_ms = secs * 64'd1000 + 64'(msecs) + 64'(it.wait_ms);
                    pos = 0;
                    while (pos < q_count && q_expiry[pos] <= exp_ms)
                        pos++;
                    for (int i = q_count; i > pos; i--)
                    begin
                        q_expiry[i] = q_expiry[i-1];
                        q_owner[i] = q_owner[i-1];
                        q_payload[i] = q_payload[i-1];
                    end
                    q_expiry[pos] = exp_ms;
                    q_owner[pos] = it.callback_id;
                    q_payload[pos] = it.event_data;
                    q_count++;
                    res.push_back(make_result(KIND_ACK, ST_OK, 0, 0, 0, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                if (it.callback_id == 0)
                    res.push_back(make_result(KIND_ACK, ST_NULL_CB, 0, 0, 0, 1'b1));
                else
                begin
                    wr = 0;
                    for (int rd = 0; rd < q_count; rd++)
                        if (q_owner[rd] != it.callback_id)
                        begin
                            q_expiry[wr] = q_expiry[rd];
                            q_owner[wr] = q_owner[rd];
                            q_payload[wr] = q_payload[rd];
                            wr++;
                        end
                    res.push_back(make_result(KIND_ACK, ST_OK, 0, 0,
                                              9'(q_count - wr), 1'b1));
                    q_count = wr;
                end
            end
            OP_TICK:
            begin
                if (!enabled)
                    res.push_back(make_result(KIND_TICK, ST_DISABLED, 0, 0, 0, 1'b1));
                else
                begin
                    rate = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
                    ticks = ticks + 1;
                    secs = ticks / rate;
                    msecs = 10'(((ticks % rate) * 64'd1000) / rate);
                    now_ms = secs * 64'd1000 + 64'(msecs);
                    while (q_count > 0 && q_expiry[0] <= now_ms)
                    begin
                        res.push_back(make_result(KIND_FIRE, ST_OK, q_owner[0],
                                                  q_payload[0], 0, 1'b0));
                        for (int i = 1; i < q_count; i++)
                        begin
                            q_expiry[i-1] = q_expiry[i];
                            q_owner[i-1] = q_owner[i];
                            q_payload[i-1] = q_payload[i];
                        end
                        q_count--;
                    end
                    next_dl = next_dl + 64'(slice_reg);
                    if (it.now > next_dl)
                    begin
                        if (missed != 32'hFFFF_FFFF)
                            missed++;
                        next_dl = it.now + 64'(slice_reg);
                    end
                    res.push_back(make_result(KIND_TICK, ST_OK, 0, 0, 0, 1'b1));
                end
            end
            default:
            begin
                if (it.operation == OP_START && !enabled)
                begin
                    next_dl = it.now + 64'(slice_reg);
                    enabled = 1'b1;
                end
                else if (it.operation == OP_STOP)
                    enabled = 1'b0;
                res.push_back(make_result(KIND_ACK, ST_OK, 0, 0, 0, 1'b1));
            end
        endcase
    endfunction

    // ---- watchdog: cycles without any input or output handshake ----
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: watchdog expired, %0d results outstanding", sb.pending.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---- output side: random stalls, check each accepted result ----
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (out_data.kind == KIND_FIRE)
                    fires_seen++;
                sb.check_result(out_data);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Send one transaction; predictor runs at the accepting edge.
    // Waits for a clock edge before starting, so valid drops between transactions.
    task automatic send_item(in_item_t it);
        out_item_t res[$];
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_timer(it, res);
        sb.note_input(res);
        in_valid <= 1'b0;
    endtask

    task automatic send_op(op_t op, logic [31:0] dly, logic [15:0] cb,
                           logic [31:0] d, logic [63:0] t);
        in_item_t it;
        it.operation = op;
        it.wait_ms = dly;
        it.callback_id = cb;
        it.event_data = d;
        it.now = t;
        send_item(it);
    endtask

    // Wait for the block to drain, then leave room for its tail latency.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TICK_RATE)
            rate_reg = val[19:0];
        else
            slice_reg = val;
    endtask

    // Mostly well-formed traffic: adds with short delays, removes, ticks, starts, stops, bad opcodes.
    task automatic random_item(int unsigned now_base);
        int pick;
        in_item_t it;
        pick = $urandom_range(99);
        it.wait_ms = ($urandom_range(9) == 0) ? $urandom : $urandom_range(30);
        it.callback_id = ($urandom_range(15) == 0) ? 16'(0) : 16'($urandom_range(1, 6));
        if ($urandom_range(19) == 0)
            it.callback_id = 16'($urandom);
        it.event_data = $urandom;
        it.now = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
            it.now = 64'(now_base) + 64'($urandom_range(200000));
        if (pick < 35)
            it.operation = OP_ADD;
        else if (pick < 45)
            it.operation = OP_REMOVE;
        else if (pick < 88)
            it.operation = OP_TICK;
        else if (pick < 94)
            it.operation = OP_START;
        else if (pick < 97)
            it.operation = OP_STOP;
        else
            it.operation = op_t'(3'($urandom_range(5, 7)));
        send_item(it);
    endtask

    initial
    begin
        int unsigned tnow;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rate_reg = 20'd100;
        slice_reg = 32'd100000;
        q_count = 0;
        ticks = '0;
        secs = '0;
        msecs = '0;
        next_dl = '0;
        missed = '0;
        enabled = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick while disabled, null callbacks, extremes, full table.
        send_op(OP_TICK, 0, 0, 0, 64'd5);
        send_op(OP_ADD, 32'd5, 16'd0, 32'hFFFF_FFFF, '0);
        send_op(OP_REMOVE, 0, 16'd0, 0, '0);
        send_op(OP_START, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_op(OP_START, 0, 0, 0, 64'd1);          // already running: no change
        for (int i = 0; i < 17; i++)                // 17th add finds the table full
            send_op(OP_ADD, (i < 3) ? 32'd10 : 32'(i), 16'(i % 3 + 1), $urandom, '0);
        send_op(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0);
        send_op(OP_REMOVE, 0, 16'd2, 0, '0);
        send_op(OP_REMOVE, 0, 16'hFFFF, 0, '0);
        send_op(OP_TICK, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(OP_TICK, 0, 0, 0, '0);
        send_op(op_t'(3'd7), 0, 0, 0, '0);
        send_op(OP_STOP, 0, 0, 0, '0);
        drain();

        // Tick rate of 1000 and the largest slice length, then a run of ticks.
        write_reg(REG_TICK_RATE, 32'd1000);
        write_reg(REG_SLICE_LENGTH, 32'hFFFF_FFFF);
        send_op(OP_START, 0, 0, 0, '0);
        for (int i = 0; i < 20; i++)
            send_op(OP_TICK, 0, 0, 0, '0);

        // Random phases with varying idling and register settings.
        tnow = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(REG_TICK_RATE, 32'd0); write_reg(REG_SLICE_LENGTH, 32'd1); end
                1: begin write_reg(REG_TICK_RATE, 32'd1000000); write_reg(REG_SLICE_LENGTH, 32'd1000); end
                2: begin write_reg(REG_TICK_RATE, 32'd1); write_reg(REG_SLICE_LENGTH, 32'd50000); end
                3: begin write_reg(REG_TICK_RATE, 32'hFFFFF); write_reg(REG_SLICE_LENGTH, 32'd3); end
                4: begin write_reg(REG_TICK_RATE, 32'd7); write_reg(REG_SLICE_LENGTH, $urandom); end
                default: begin write_reg(REG_TICK_RATE, 32'd333); write_reg(REG_SLICE_LENGTH, 32'd100000); end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 78; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 78; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            send_op(OP_START, 0, 0, 0, 64'(tnow));
            for (int n = 0; n < 70; n++)
            begin
                tnow += 40000;
                random_item(tnow);
            end
        end

        // Extra adds and ticks until enough events have fired.
        send_op(OP_START, 0, 0, 0, 64'(tnow));
        for (int n = 0; n < 60 && fires_seen < 48; n++)
        begin
            send_op(OP_ADD, $urandom_range(3), 16'($urandom_range(1, 6)), $urandom, '0);
            send_op(OP_TICK, 0, 0, 0, 64'(tnow));
        end
        drain();

        $display("tb: %0d results checked, %0d expired events, rates 0..max and slices 1..max",
                 sb.checked, fires_seen);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
